FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// implication checked in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

FILE: design/rv32_pkg.sv
// shared opcodes, status codes and types of the instruction step core
package rv32_pkg;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_ECALL   = 2'd2;
   localparam logic [1:0] ST_HALTED  = 2'd3;

   localparam logic [31:0] SVC_EXIT      = 32'd10;
   localparam logic [31:0] SVC_EXIT_CODE = 32'd17;
   localparam logic [31:0] UPPER_MASK    = 32'hFFFFF000;

   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU, ALU_XOR, ALU_SRL, ALU_SRA, ALU_OR, ALU_AND
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;
endpackage

FILE: design/rv32_alu.sv
// shared arithmetic, compare and shift unit
module rv32_alu (
   input  rv32_pkg::alu_req_type req,
   output logic [31:0]           result
);
   logic [4:0] shamt;
   assign shamt = req.b[4:0];
   always_comb begin
      unique case (req.op)
         rv32_pkg::ALU_ADD:  result = req.a + req.b;
         rv32_pkg::ALU_SUB:  result = req.a - req.b;
         rv32_pkg::ALU_SLL:  result = req.a << shamt;
         rv32_pkg::ALU_SLT:  result = {31'd0, $signed(req.a) < $signed(req.b)};
         rv32_pkg::ALU_SLTU: result = {31'd0, req.a < req.b};
         rv32_pkg::ALU_XOR:  result = req.a ^ req.b;
         rv32_pkg::ALU_SRL:  result = req.a >> shamt;
         rv32_pkg::ALU_SRA:  result = $unsigned($signed(req.a) >>> shamt);
         rv32_pkg::ALU_OR:   result = req.a | req.b;
         rv32_pkg::ALU_AND:  result = req.a & req.b;
         default:            result = req.a + req.b;
      endcase
   end
endmodule

FILE: design/rv32_regfile.sv
// 32 x 32 register file, x0 reads zero, two registered read ports
module rv32_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);
   logic [31:0] regs_ff [32];
   logic [31:0] valid_ff;
   logic [31:0] a_ff, b_ff;
   logic        a_ok_ff, b_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
      if (wr_en) begin
         regs_ff[wr_addr] <= wr_data;
      end
      a_ff    <= regs_ff[rd_addr_a];
      b_ff    <= regs_ff[rd_addr_b];
      a_ok_ff <= valid_ff[rd_addr_a] && (rd_addr_a != 5'd0);
      b_ok_ff <= valid_ff[rd_addr_b] && (rd_addr_b != 5'd0);
   end
   assign rd_data_a = a_ok_ff ? a_ff : 32'd0;
   assign rd_data_b = b_ok_ff ? b_ff : 32'd0;
endmodule

FILE: design/rv32_instruction_step.sv
// word memory with one write port and one registered read port, shared by fetch, loads and stores
module rv32_mem #(
   parameter int MEM_WORDS = 4096
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(MEM_WORDS)-1:0] wr_addr,
   input  logic [31:0]                  wr_data,
   input  logic [$clog2(MEM_WORDS)-1:0] rd_addr,
   output logic [31:0]                  rd_data
);
   logic [31:0] mem [MEM_WORDS];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: design/rv32i_instruction_step.sv
// from accept to result: a program word write or a halted step passes only S_DONE, an executed
// instruction S_FETCH, S_DECODE, S_EXEC, S_DONE; legal loads and stores add the S_MEM memory pass
// throughput: busy stays high until the result strobe, and the next transaction can be
// accepted at the edge that takes the result; the one memory read port and shared alu set this
// synchronous reset clears pc, halt flag and register file (valid bits); memory keeps contents
// results cannot be stalled: rsp_valid is a one-cycle strobe
module rv32i_instruction_step #(
   parameter int MEM_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [11:0] req_word_address,
   input  logic [31:0] req_word_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_next_pc,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic        rsp_reg_written,
   output logic        rsp_mem_written,
   output logic [31:0] rsp_service_code,
   output logic [31:0] rsp_argument_value
);
   localparam int AW = $clog2(MEM_WORDS);

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_MEM, S_DONE
   } state_type;

   state_type   state_ff;
   logic [31:0] pc_ff, ins_ff, res_ff, svc_ff, arg_ff, addr_ff;
   logic        halted_ff, rw_ff, mw_ff;
   logic [1:0]  status_ff;
   logic [4:0]  dest_ff;

   // memory port
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [31:0]   mem_wdata, mem_rdata;

   rv32_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
      .rd_addr(mem_raddr), .rd_data(mem_rdata)
   );

   // decode fields
   logic [6:0]  op;
   logic [2:0]  f3;
   logic [4:0]  rd, rs2;
   logic        alt;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
   assign op    = ins_ff[6:0];
   assign rd    = ins_ff[11:7];
   assign f3    = ins_ff[14:12];
   assign rs2   = ins_ff[24:20];
   assign alt   = ins_ff[30];
   assign imm_i = {{20{ins_ff[31]}}, ins_ff[31:20]};
   assign imm_s = {{20{ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
   assign imm_b = {{19{ins_ff[31]}}, ins_ff[31], ins_ff[7], ins_ff[30:25], ins_ff[11:8], 1'b0};
   assign imm_j = {{11{ins_ff[31]}}, ins_ff[31], ins_ff[19:12], ins_ff[20], ins_ff[30:21], 1'b0};
   assign imm_u = ins_ff[31:0] & rv32_pkg::UPPER_MASK;

   // register file; in decode the ecall reads x17 and x10 instead
   logic        is_sys;
   logic [4:0]  ra, rb;
   logic [31:0] rva, rvb;
   logic        rf_we;
   logic [31:0] rf_wdata;
   assign is_sys = (mem_rdata[6:0] == rv32_pkg::OP_SYSTEM);
   assign ra = is_sys ? 5'd17 : mem_rdata[19:15];
   assign rb = is_sys ? 5'd10 : mem_rdata[24:20];

   rv32_regfile u_rf (
      .clock(clock), .reset(reset), .rd_addr_a(ra), .rd_addr_b(rb),
      .rd_data_a(rva), .rd_data_b(rvb), .wr_en(rf_we), .wr_addr(dest_ff), .wr_data(rf_wdata)
   );

   // shared alu
   rv32_pkg::alu_req_type alu_req;
   logic [31:0]           alu_y;
   rv32_alu u_alu (.req(alu_req), .result(alu_y));

   always_comb begin
      alu_req.op = rv32_pkg::ALU_ADD;
      alu_req.a  = rva;
      alu_req.b  = imm_i;
      unique case (op)
         rv32_pkg::OP_LUI:   begin alu_req.a = 32'd0; alu_req.b = imm_u; end
         rv32_pkg::OP_AUIPC: begin alu_req.a = pc_ff; alu_req.b = imm_u; end
         rv32_pkg::OP_JAL:   begin alu_req.a = pc_ff; alu_req.b = imm_j; end
         rv32_pkg::OP_STORE: alu_req.b = imm_s;
         rv32_pkg::OP_BRANCH: begin
            alu_req.b = rvb;
            unique case (f3)
               3'd4, 3'd5: alu_req.op = rv32_pkg::ALU_SLT;
               3'd6, 3'd7: alu_req.op = rv32_pkg::ALU_SLTU;
               default:    alu_req.op = rv32_pkg::ALU_XOR;
            endcase
         end
         rv32_pkg::OP_IMM, rv32_pkg::OP_REG: begin
            if (op == rv32_pkg::OP_REG) begin
               alu_req.b = rvb;
            end else if (f3 == 3'd1 || f3 == 3'd5) begin
               alu_req.b = {27'd0, rs2};
            end
            unique case (f3)
               3'd0: alu_req.op = (alt && op == rv32_pkg::OP_REG) ? rv32_pkg::ALU_SUB
                                                                : rv32_pkg::ALU_ADD;
               3'd1: alu_req.op = rv32_pkg::ALU_SLL;
               3'd2: alu_req.op = rv32_pkg::ALU_SLT;
               3'd3: alu_req.op = rv32_pkg::ALU_SLTU;
               3'd4: alu_req.op = rv32_pkg::ALU_XOR;
               3'd5: alu_req.op = alt ? rv32_pkg::ALU_SRA : rv32_pkg::ALU_SRL;
               3'd6: alu_req.op = rv32_pkg::ALU_OR;
               default: alu_req.op = rv32_pkg::ALU_AND;
            endcase
         end
         default: ;
      endcase
   end

   // branch decision from the alu result
   logic take;
   always_comb begin
      unique case (f3)
         3'd0:    take = (alu_y == 32'd0);
         3'd1:    take = (alu_y != 32'd0);
         3'd4, 3'd6: take = alu_y[0];
         3'd5, 3'd7: take = !alu_y[0];
         default: take = 1'b0;
      endcase
   end

   // load lane extraction and store merge
   logic [7:0]  lb;
   logic [15:0] lh;
   logic [31:0] load_val, store_val;
   assign lb = mem_rdata[{addr_ff[1:0], 3'b000} +: 8];
   assign lh = mem_rdata[{addr_ff[1], 4'b0000} +: 16];
   always_comb begin
      case (f3)
         3'd0:    load_val = {{24{lb[7]}}, lb};
         3'd1:    load_val = {{16{lh[15]}}, lh};
         3'd4:    load_val = {24'd0, lb};
         3'd5:    load_val = {16'd0, lh};
         default: load_val = mem_rdata;
      endcase
      store_val = mem_rdata;
      case (f3)
         3'd0:    store_val[{addr_ff[1:0], 3'b000} +: 8] = rvb[7:0];
         3'd1:    store_val[{addr_ff[1], 4'b0000} +: 16] = rvb[15:0];
         default: store_val = rvb;
      endcase
   end

   logic [31:0] pc4;
   assign pc4 = pc_ff + 32'd4;

   // next pc, status and whether a data memory pass follows
   logic [31:0] exec_pc;
   logic [1:0]  exec_status;
   logic        exec_mem, sys_halt;
   assign sys_halt = (rva == rv32_pkg::SVC_EXIT) || (rva == rv32_pkg::SVC_EXIT_CODE);
   always_comb begin
      exec_pc     = pc4;
      exec_status = rv32_pkg::ST_OK;
      exec_mem    = 1'b0;
      unique case (op)
         rv32_pkg::OP_LUI, rv32_pkg::OP_AUIPC, rv32_pkg::OP_IMM, rv32_pkg::OP_REG: ;
         rv32_pkg::OP_JAL:  exec_pc = alu_y;
         rv32_pkg::OP_JALR: exec_pc = {alu_y[31:1], 1'b0};
         rv32_pkg::OP_BRANCH: begin
            if (f3 == 3'd2 || f3 == 3'd3) begin
               exec_status = rv32_pkg::ST_ILLEGAL;
            end else if (take) begin
               exec_pc = pc_ff + imm_b;
            end
         end
         rv32_pkg::OP_LOAD: begin
            if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
               exec_status = rv32_pkg::ST_ILLEGAL;
            end else begin
               exec_mem = 1'b1;
            end
         end
         rv32_pkg::OP_STORE: begin
            if (f3 > 3'd2) begin
               exec_status = rv32_pkg::ST_ILLEGAL;
            end else begin
               exec_mem = 1'b1;
            end
         end
         rv32_pkg::OP_SYSTEM: exec_status = sys_halt ? rv32_pkg::ST_HALTED : rv32_pkg::ST_ECALL;
         default: exec_status = rv32_pkg::ST_ILLEGAL;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(req_word_address);
      mem_wdata = req_word_data;
      mem_raddr = pc_ff[AW+1:2];
      if (state_ff == S_IDLE && start && req_command == 1'b0) begin
         mem_we = 1'b1;
      end else if (state_ff == S_EXEC) begin
         mem_raddr = alu_y[AW+1:2];
      end else if (state_ff == S_MEM && op == rv32_pkg::OP_STORE) begin
         mem_we    = 1'b1;
         mem_waddr = addr_ff[AW+1:2];
         mem_wdata = store_val;
      end
      rf_we    = 1'b0;
      rf_wdata = res_ff;
      if (state_ff == S_EXEC && op != rv32_pkg::OP_LOAD && dest_ff != 5'd0) begin
         rf_we    = 1'b1;
         rf_wdata = (op == rv32_pkg::OP_JAL || op == rv32_pkg::OP_JALR) ? pc4 : alu_y;
      end else if (state_ff == S_MEM && op == rv32_pkg::OP_LOAD && dest_ff != 5'd0) begin
         rf_we    = 1'b1;
         rf_wdata = load_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pc_ff     <= 32'd0;
         halted_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == S_DONE);
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  status_ff <= (req_command && halted_ff) ? rv32_pkg::ST_HALTED
                                                          : rv32_pkg::ST_OK;
                  dest_ff   <= 5'd0;
                  res_ff    <= 32'd0;
                  rw_ff     <= 1'b0;
                  mw_ff     <= 1'b0;
                  svc_ff    <= 32'd0;
                  arg_ff    <= 32'd0;
                  state_ff  <= (req_command && !halted_ff) ? S_FETCH : S_DONE;
               end
            end
            S_FETCH: begin
               ins_ff   <= mem_rdata;
               state_ff <= S_DECODE;
            end
            S_DECODE: begin
               // register reads settle this cycle
               if (op == rv32_pkg::OP_LUI || op == rv32_pkg::OP_AUIPC ||
                   op == rv32_pkg::OP_JAL || op == rv32_pkg::OP_JALR ||
                   op == rv32_pkg::OP_LOAD || op == rv32_pkg::OP_IMM ||
                   op == rv32_pkg::OP_REG) begin
                  dest_ff <= rd;
               end
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               pc_ff     <= exec_pc;
               status_ff <= exec_status;
               state_ff  <= exec_mem ? S_MEM : S_DONE;
               addr_ff   <= alu_y;
               if (op != rv32_pkg::OP_LOAD && dest_ff != 5'd0) begin
                  res_ff <= rf_wdata;
                  rw_ff  <= 1'b1;
               end else if (!exec_mem) begin
                  dest_ff <= 5'd0;
               end
               if (op == rv32_pkg::OP_SYSTEM) begin
                  svc_ff    <= rva;
                  arg_ff    <= rvb;
                  halted_ff <= sys_halt;
               end
            end
            S_MEM: begin
               if (op == rv32_pkg::OP_STORE) begin
                  mw_ff <= 1'b1;
               end else if (dest_ff != 5'd0) begin
                  res_ff <= load_val;
                  rw_ff  <= 1'b1;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // the instruction word stays on the memory output through decode, so register reads repeat
   assign busy               = (state_ff != S_IDLE);
   assign rsp_status         = status_ff;
   assign rsp_next_pc        = pc_ff;
   assign rsp_dest_index     = dest_ff;
   assign rsp_dest_value     = res_ff;
   assign rsp_reg_written    = rw_ff;
   assign rsp_mem_written    = mw_ff;
   assign rsp_service_code   = svc_ff;
   assign rsp_argument_value = arg_ff;
endmodule

FILE: design/rv32_checker.sv
// port-level checks of the instruction step core, bound to the top level
`include "assert_macros.svh"
module rv32_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic       rsp_reg_written,
   input logic [4:0] rsp_dest_index,
   input logic       rsp_mem_written
);
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "busy missing after start")
   `ASSERT_NEXT(a_strobe_once, clock, reset, rsp_valid, !rsp_valid, "result strobe too long")
   `ASSERT_IMPLIES(a_x0, clock, reset, rsp_valid && rsp_reg_written, rsp_dest_index != 5'd0,
      "x0 reported as written")
   `ASSERT_IMPLIES(a_excl, clock, reset, rsp_valid, !(rsp_reg_written && rsp_mem_written),
      "register and memory both written")
   `ASSERT_IMPLIES(a_store_ok, clock, reset, rsp_valid && rsp_mem_written,
      rsp_status == rv32_pkg::ST_OK, "store reported with a bad status")
endmodule

bind rv32i_instruction_step rv32_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_status(rsp_status), .rsp_reg_written(rsp_reg_written),
   .rsp_dest_index(rsp_dest_index), .rsp_mem_written(rsp_mem_written)
);

FILE: bench/rv32i_instruction_step_tb.sv
// self-checking testbench of the rv32i instruction step core
`timescale 1ns / 100ps

module rv32i_instruction_step_tb;
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;
   localparam logic [2:0] F3_LB   = 3'd0;
   localparam logic [2:0] F3_LH   = 3'd1;
   localparam logic [2:0] F3_LW   = 3'd2;
   localparam logic [2:0] F3_LBU  = 3'd4;
   localparam logic [2:0] F3_LHU  = 3'd5;
   localparam logic [2:0] F3_SB   = 3'd0;
   localparam logic [2:0] F3_SH   = 3'd1;
   localparam logic [2:0] F3_SW   = 3'd2;

   localparam int ITEM_TARGET = 1850;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] next_pc;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic        reg_written;
      logic        mem_written;
      logic [31:0] service_code;
      logic [31:0] argument_value;
   } step_result_type;

   typedef struct {
      logic            cmd;
      logic [11:0]     addr;
      logic [31:0]     data;
      bit              typed;
      step_result_type typed_exp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = 1'b0;
   logic [11:0] req_word_address = '0;
   logic [31:0] req_word_data = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_next_pc;
   logic [4:0]  rsp_dest_index;
   logic [31:0] rsp_dest_value;
   logic        rsp_reg_written;
   logic        rsp_mem_written;
   logic [31:0] rsp_service_code;
   logic [31:0] rsp_argument_value;

   // shadow state of the core
   logic [31:0] core_regs [0:31];
   logic [31:0] core_pc;
   logic        core_halted;
   logic [31:0] core_mem [0:4095];
   bit          mem_known [0:4095];

   step_result_type expected_q[$];
   stim_row_type    directed_rows[$];
   int              error_count = 0;
   int              items_sent = 0;

   rv32i_instruction_step i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_word_address(req_word_address),
      .req_word_data(req_word_data), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_next_pc(rsp_next_pc), .rsp_dest_index(rsp_dest_index),
      .rsp_dest_value(rsp_dest_value), .rsp_reg_written(rsp_reg_written),
      .rsp_mem_written(rsp_mem_written), .rsp_service_code(rsp_service_code),
      .rsp_argument_value(rsp_argument_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] enc_i(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                         logic [4:0] rs1, logic [11:0] imm);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, rv32_pkg::OP_REG};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], rv32_pkg::OP_STORE};
   endfunction

   function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32_pkg::OP_JAL};
   endfunction

   function automatic logic [31:0] alu_result(logic [2:0] f3, logic alt, logic [31:0] a,
                                              logic [31:0] b, logic allow_sub);
      case (f3)
         F3_ADD:  return (alt && allow_sub) ? a - b : a + b;
         F3_SLL:  return a << b[4:0];
         F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
         F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
         F3_XOR:  return a ^ b;
         F3_SR:   return alt ? $unsigned($signed(a) >>> b[4:0]) : a >> b[4:0];
         F3_OR:   return a | b;
         default: return a & b;
      endcase
   endfunction

   // applies one transaction to the shadow state and returns what the core should report
   function automatic step_result_type execute_transaction(logic cmd, logic [11:0] addr,
                                                           logic [31:0] data);
      step_result_type r;
      logic [31:0] ins, a, b, imm_i, imm_s, imm_b, imm_j, npc, res, ea, w;
      logic [15:0] half;
      logic [7:0]  byte_v;
      logic [6:0]  op;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic        alt, has_rd, take;
      r = '0;
      if (cmd == CMD_WRITE) begin
         core_mem[addr] = data;
         mem_known[addr] = 1'b1;
         r.next_pc = core_pc;
         return r;
      end
      if (core_halted) begin
         r.status = rv32_pkg::ST_HALTED;
         r.next_pc = core_pc;
         return r;
      end
      ins = core_mem[core_pc[13:2]];
      op = ins[6:0];
      rd = ins[11:7];
      f3 = ins[14:12];
      a = core_regs[ins[19:15]];
      b = core_regs[ins[24:20]];
      alt = ins[30];
      imm_i = {{20{ins[31]}}, ins[31:20]};
      imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      npc = core_pc + 32'd4;
      has_rd = 1'b0;
      res = '0;
      r.status = rv32_pkg::ST_OK;
      case (op)
         rv32_pkg::OP_LUI: begin
            has_rd = 1'b1;
            res = ins & rv32_pkg::UPPER_MASK;
         end
         rv32_pkg::OP_AUIPC: begin
            has_rd = 1'b1;
            res = core_pc + (ins & rv32_pkg::UPPER_MASK);
         end
         rv32_pkg::OP_JAL: begin
            has_rd = 1'b1;
            res = core_pc + 32'd4;
            npc = core_pc + imm_j;
         end
         rv32_pkg::OP_JALR: begin
            has_rd = 1'b1;
            res = core_pc + 32'd4;
            npc = (a + imm_i) & ~32'd1;
         end
         rv32_pkg::OP_BRANCH: begin
            take = 1'b0;
            case (f3)
               F3_BEQ:  take = (a == b);
               F3_BNE:  take = (a != b);
               F3_BLT:  take = ($signed(a) < $signed(b));
               F3_BGE:  take = !($signed(a) < $signed(b));
               F3_BLTU: take = (a < b);
               F3_BGEU: take = (a >= b);
               default: r.status = rv32_pkg::ST_ILLEGAL;
            endcase
            if (take) npc = core_pc + imm_b;
         end
         rv32_pkg::OP_LOAD: begin
            ea = a + imm_i;
            w = core_mem[ea[13:2]];
            byte_v = w[{ea[1:0], 3'b000} +: 8];
            half = ea[1] ? w[31:16] : w[15:0];
            has_rd = 1'b1;
            case (f3)
               F3_LB:   res = {{24{byte_v[7]}}, byte_v};
               F3_LH:   res = {{16{half[15]}}, half};
               F3_LW:   res = w;
               F3_LBU:  res = {24'd0, byte_v};
               F3_LHU:  res = {16'd0, half};
               default: begin
                  has_rd = 1'b0;
                  r.status = rv32_pkg::ST_ILLEGAL;
               end
            endcase
         end
         rv32_pkg::OP_STORE: begin
            ea = a + imm_s;
            w = core_mem[ea[13:2]];
            r.mem_written = 1'b1;
            case (f3)
               F3_SB: w[{ea[1:0], 3'b000} +: 8] = b[7:0];
               F3_SH: begin
                  if (ea[1]) w[31:16] = b[15:0];
                  else w[15:0] = b[15:0];
               end
               F3_SW: w = b;
               default: begin
                  r.mem_written = 1'b0;
                  r.status = rv32_pkg::ST_ILLEGAL;
               end
            endcase
            if (r.mem_written) begin
               core_mem[ea[13:2]] = w;
               mem_known[ea[13:2]] = 1'b1;
            end
         end
         rv32_pkg::OP_IMM: begin
            has_rd = 1'b1;
            res = alu_result(f3, alt, a,
                             (f3 == F3_SLL || f3 == F3_SR) ? {27'd0, ins[24:20]} : imm_i, 1'b0);
         end
         rv32_pkg::OP_REG: begin
            has_rd = 1'b1;
            res = alu_result(f3, alt, a, b, 1'b1);
         end
         rv32_pkg::OP_SYSTEM: begin
            r.service_code = core_regs[17];
            r.argument_value = core_regs[10];
            if (core_regs[17] == rv32_pkg::SVC_EXIT ||
                core_regs[17] == rv32_pkg::SVC_EXIT_CODE) begin
               core_halted = 1'b1;
               r.status = rv32_pkg::ST_HALTED;
            end else begin
               r.status = rv32_pkg::ST_ECALL;
            end
         end
         default: r.status = rv32_pkg::ST_ILLEGAL;
      endcase
      if (has_rd && rd != 5'd0) begin
         core_regs[rd] = res;
         r.dest_index = rd;
         r.dest_value = res;
         r.reg_written = 1'b1;
      end
      core_pc = npc;
      r.next_pc = core_pc;
      return r;
   endfunction

   function automatic logic [31:0] random_instruction();
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      logic [11:0] imm;
      logic [31:0] raw;
      rd = 5'($urandom);
      rs1 = 5'($urandom);
      rs2 = 5'($urandom);
      f3 = 3'($urandom);
      imm = 12'($urandom);
      raw = $urandom;
      case ($urandom_range(0, 13))
         0:       return {raw[31:12], rd, rv32_pkg::OP_LUI};
         1:       return {raw[31:12], rd, rv32_pkg::OP_AUIPC};
         2:       return enc_j(rd, raw[20:0]);
         3:       return enc_i(rv32_pkg::OP_JALR, rd, F3_ADD, rs1, imm);
         4:       return {raw[31:25], rs2, rs1, f3, raw[11:7], rv32_pkg::OP_BRANCH};
         5, 6:    return enc_i(rv32_pkg::OP_LOAD, rd, f3, rs1, imm);
         7, 8:    return enc_s(imm, rs2, rs1, f3);
         9, 10:   return enc_i(rv32_pkg::OP_IMM, rd, f3, rs1, imm);
         11, 12:  return enc_r(raw[31:25], rs2, rs1, f3, rd);
         default: return ($urandom_range(0, 1) == 0) ? {raw[31:7], rv32_pkg::OP_SYSTEM} : raw;
      endcase
   endfunction

   function automatic int gap_length();
      int pick;
      // every fourth stretch of items runs with no gaps
      if ((items_sent / 150) % 4 == 3) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic issue(input logic cmd, input logic [11:0] addr, input logic [31:0] data,
                        input bit typed, input step_result_type typed_exp);
      step_result_type predicted;
      int gap;
      req_command <= cmd;
      req_word_address <= addr;
      req_word_data <= data;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = execute_transaction(cmd, addr, data);
      expected_q.push_back(typed ? typed_exp : predicted);
      items_sent++;
      gap = gap_length();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic add_row(input logic cmd, input logic [11:0] addr, input logic [31:0] data,
                          input bit typed, input step_result_type typed_exp);
      stim_row_type row;
      row.cmd = cmd;
      row.addr = addr;
      row.data = data;
      row.typed = typed;
      row.typed_exp = typed_exp;
      directed_rows.push_back(row);
   endtask

   // result checker
   always @(posedge clock) begin
      step_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected transaction, pc", rsp_next_pc, '0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_next_pc !== want.next_pc)
               report_mismatch("next_pc", rsp_next_pc, want.next_pc);
            if (rsp_dest_index !== want.dest_index)
               report_mismatch("dest_index", 32'(rsp_dest_index), 32'(want.dest_index));
            if (rsp_dest_value !== want.dest_value)
               report_mismatch("dest_value", rsp_dest_value, want.dest_value);
            if (rsp_reg_written !== want.reg_written)
               report_mismatch("reg_written", 32'(rsp_reg_written), 32'(want.reg_written));
            if (rsp_mem_written !== want.mem_written)
               report_mismatch("mem_written", 32'(rsp_mem_written), 32'(want.mem_written));
            if (rsp_service_code !== want.service_code)
               report_mismatch("service_code", rsp_service_code, want.service_code);
            if (rsp_argument_value !== want.argument_value)
               report_mismatch("argument_value", rsp_argument_value, want.argument_value);
         end
      end
   end

   initial begin
      #5ms;
      $display("timeout waiting for transactions");
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      step_result_type none, known;
      logic [31:0] ins, ea;
      int drain;
      bit drained;
      none = '0;
      drained = 1'b0;
      for (int i = 0; i < 32; i++) core_regs[i] = '0;
      for (int i = 0; i < 4096; i++) begin
         core_mem[i] = '0;
         mem_known[i] = 1'b0;
      end
      core_pc = '0;
      core_halted = 1'b0;

      // short program at words 0..9, then stepped through once and back to the start
      add_row(CMD_WRITE, 12'd0, {20'h80000, 5'd1, rv32_pkg::OP_LUI}, 1'b1, none);
      add_row(CMD_WRITE, 12'd1, enc_i(rv32_pkg::OP_IMM, 5'd2, F3_ADD, 5'd0, 12'hFFF), 1'b0, none);
      add_row(CMD_WRITE, 12'd2, enc_i(rv32_pkg::OP_IMM, 5'd3, F3_SR, 5'd1, 12'h41F), 1'b0, none);
      add_row(CMD_WRITE, 12'd3, enc_r(7'h20, 5'd2, 5'd0, F3_ADD, 5'd4), 1'b0, none);
      add_row(CMD_WRITE, 12'd4, enc_s(12'h400, 5'd1, 5'd0, F3_SW), 1'b0, none);
      add_row(CMD_WRITE, 12'd5, enc_i(rv32_pkg::OP_LOAD, 5'd6, F3_LH, 5'd0, 12'h402), 1'b0,
              none);
      // writes x0, must report nothing written
      add_row(CMD_WRITE, 12'd6, enc_r(7'h00, 5'd1, 5'd1, F3_ADD, 5'd0), 1'b0, none);
      add_row(CMD_WRITE, 12'd7, 32'hFFFF_FFFF, 1'b0, none);
      add_row(CMD_WRITE, 12'd8, {25'd0, rv32_pkg::OP_SYSTEM}, 1'b0, none);
      add_row(CMD_WRITE, 12'd9, enc_j(5'd7, -21'sd36), 1'b0, none);
      for (int s = 0; s < 11; s++) begin
         known = none;
         if (s == 7) begin
            known.status = rv32_pkg::ST_ILLEGAL;
            known.next_pc = 32'd32;
         end else if (s == 8) begin
            known.status = rv32_pkg::ST_ECALL;
            known.next_pc = 32'd36;
         end
         add_row(CMD_STEP, 12'hFFF, 32'hFFFF_FFFF, (s == 7 || s == 8), known);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].data,
               directed_rows[i].typed, directed_rows[i].typed_exp);

      while (items_sent < ITEM_TARGET) begin
         if (!drained && items_sent > 900) begin
            // hold off until the core has answered everything
            drained = 1'b1;
            start <= 1'b0;
            while (expected_q.size() != 0) @(posedge clock);
            @(posedge clock);
         end
         if ($urandom_range(0, 9) == 0)
            issue(CMD_WRITE, 12'($urandom), $urandom, 1'b0, none);
         ins = random_instruction();
         // keep the core running until the final phase
         if (ins[6:0] == rv32_pkg::OP_SYSTEM &&
             (core_regs[17] == rv32_pkg::SVC_EXIT || core_regs[17] == rv32_pkg::SVC_EXIT_CODE))
            ins[6:0] = rv32_pkg::OP_IMM;
         issue(CMD_WRITE, core_pc[13:2], ins, 1'b0, none);
         // loads and partial stores only touch words that hold known data
         if (ins[6:0] == rv32_pkg::OP_LOAD || ins[6:0] == rv32_pkg::OP_STORE) begin
            if (ins[6:0] == rv32_pkg::OP_LOAD)
               ea = core_regs[ins[19:15]] + {{20{ins[31]}}, ins[31:20]};
            else
               ea = core_regs[ins[19:15]] + {{20{ins[31]}}, ins[31:25], ins[11:7]};
            if (!mem_known[ea[13:2]]) issue(CMD_WRITE, ea[13:2], $urandom, 1'b0, none);
         end
         issue(CMD_STEP, 12'($urandom), $urandom, 1'b0, none);
      end

      // halt with an exit code, then poke the halted core
      issue(CMD_WRITE, core_pc[13:2], enc_i(rv32_pkg::OP_IMM, 5'd17, F3_ADD, 5'd0, 12'd17),
            1'b0, none);
      issue(CMD_STEP, '0, '0, 1'b0, none);
      issue(CMD_WRITE, core_pc[13:2], enc_i(rv32_pkg::OP_IMM, 5'd10, F3_ADD, 5'd0, 12'h800),
            1'b0, none);
      issue(CMD_STEP, '0, '0, 1'b0, none);
      issue(CMD_WRITE, core_pc[13:2], {25'd0, rv32_pkg::OP_SYSTEM}, 1'b0, none);
      issue(CMD_STEP, '0, '0, 1'b0, none);
      issue(CMD_STEP, '0, '0, 1'b0, none);
      issue(CMD_WRITE, 12'hABC, 32'h1234_5678, 1'b0, none);
      start <= 1'b0;

      drain = 0;
      while (expected_q.size() != 0 && drain < 1000) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
